// ===== src/vcs_pkg.sv =====
// Shared constants, signature tables and types for the video container sniffer.
package vcs_pkg;

    localparam int POS_W         = 9;
    localparam int LEN_W         = POS_W + 1;
    localparam int NUM_HEAD_SIGS = 8;
    localparam int NUM_SIGS      = 9;
    localparam int HEAD_LEN      = 16;
    localparam int TS_FLAG_BIT   = 8;

    localparam logic [POS_W-1:0]    POS_MAX    = 9'd511;
    localparam logic [POS_W-1:0]    TS_POS_A   = 9'd188;
    localparam logic [POS_W-1:0]    TS_POS_B   = 9'd376;
    localparam logic [LEN_W-1:0]    TS_MIN_LEN = 10'd377;
    localparam logic [7:0]          TS_SYNC    = 8'h47;
    localparam logic [NUM_SIGS-1:0] ALL_FLAGS  = 9'h1FF;

    // Result codes, lowest nonzero code has highest priority
    typedef enum logic [3:0] {
        CODE_UNKNOWN = 4'd0,
        CODE_MKV     = 4'd1,
        CODE_MP4     = 4'd2,
        CODE_AVI     = 4'd3,
        CODE_MPS     = 4'd4,
        CODE_ASF     = 4'd5,
        CODE_FLV     = 4'd6,
        CODE_OGG     = 4'd7,
        CODE_RM      = 4'd8,
        CODE_MTS     = 4'd9
    } container_t;

    // Expected header bytes per signature, by offset 0..15
    localparam logic [7:0] SIG_BYTES [NUM_HEAD_SIGS][HEAD_LEN] = '{
        '{8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h74, 8'h79, 8'h70,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h41, 8'h56, 8'h49, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h01, 8'hBA, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
          8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C},
        '{8'h46, 8'h4C, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2E, 8'h52, 8'h4D, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Offsets that are compared for each signature
    localparam logic [HEAD_LEN-1:0] SIG_CARE [NUM_HEAD_SIGS] = '{
        16'h000F, 16'h00F0, 16'h0F0F, 16'h000F,
        16'hFFFF, 16'h0007, 16'h000F, 16'h000F
    };

    // Minimum buffer length for each signature
    localparam logic [LEN_W-1:0] SIG_MIN_LEN [NUM_HEAD_SIGS] = '{
        10'd4, 10'd8, 10'd12, 10'd4, 10'd16, 10'd3, 10'd4, 10'd4
    };

endpackage

// ===== src/vcs_match.sv =====
// Per-byte signature compare, length check and priority pick.
module vcs_match
    import vcs_pkg::*;
(
    input  logic [POS_W-1:0]    pos,
    input  logic [NUM_SIGS-1:0] flags,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic [NUM_SIGS-1:0] flags_upd,
    output container_t          code
);

    logic [NUM_SIGS-1:0] flags_len;
    logic [LEN_W-1:0]    len;
    logic [3:0]          head_pos;
    logic                in_head;
    logic                ts_pos;

    assign head_pos = pos[3:0];
    assign in_head  = (pos < POS_W'(HEAD_LEN));
    assign ts_pos   = (pos == '0) || (pos == TS_POS_A) || (pos == TS_POS_B);
    assign len      = {1'b0, pos} + LEN_W'(1);

    // Clear flags contradicted by this byte
    always_comb
    begin
        flags_upd = flags;
        for (int i = 0; i < NUM_HEAD_SIGS; i++)
        begin
            if (in_head && SIG_CARE[i][head_pos] && (SIG_BYTES[i][head_pos] != data_byte))
            begin
                flags_upd[i] = 1'b0;
            end
        end
        if (ts_pos && (data_byte != TS_SYNC))
        begin
            flags_upd[TS_FLAG_BIT] = 1'b0;
        end
    end

    // Drop signatures whose minimum length was not reached
    always_comb
    begin
        flags_len = flags_upd;
        for (int i = 0; i < NUM_HEAD_SIGS; i++)
        begin
            if (len < SIG_MIN_LEN[i])
            begin
                flags_len[i] = 1'b0;
            end
        end
        if (len < TS_MIN_LEN)
        begin
            flags_len[TS_FLAG_BIT] = 1'b0;
        end
    end

    // First surviving signature wins; only meaningful on the last byte
    always_comb
    begin
        code = CODE_UNKNOWN;
        for (int i = NUM_SIGS - 1; i >= 0; i--)
        begin
            if (flags_len[i] && last_byte)
            begin
                code = container_t'(4'(i + 1));
            end
        end
    end

endmodule

// ===== src/video_container_sniffer.sv =====
// Top level of the video container sniffer: input register, state, result register.
//
// Usage: feed the bytes of a buffer in order from offset zero on the input
// channel (in_valid/in_stall, data_byte, last_byte), one word per byte, with
// last_byte set on the final byte. Every buffer holds at least one byte.
// For each buffer one result word comes out on the output channel
// (out_valid/out_stall, container): 0 unknown, 1 mkv, 2 mp4, 3 avi,
// 4 mpeg-ps, 5 asf, 6 flv, 7 ogg, 8 rm, 9 mpeg-ts.
// Throughput: one byte per cycle, back to back across buffers, except while a
// last byte waits behind a held result. A last byte goes through the input
// register and then the result register, which raises out_valid.
// The compare for a byte sits between the input register and the result
// register; byte position (saturating at 511) and match flags update when
// the registered byte is consumed.
// Reset clears both registers' valid bits, the position and sets all flags.
// When the receiver stalls, the result holds; non-last bytes keep flowing,
// and the next last byte waits in the input register, raising in_stall.
module video_container_sniffer
    import vcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] container
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [NUM_SIGS-1:0] flags_reg, flags_next;
    logic                out_valid_reg, out_valid_next;
    container_t          container_reg;
    logic [NUM_SIGS-1:0] flags_upd;
    container_t          code;
    logic                advance;
    logic                in_take;

    // Registered word moves on unless it is a last byte blocked by a held result
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    vcs_match u_match (
        .pos       (pos_reg),
        .flags     (flags_reg),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .flags_upd (flags_upd),
        .code      (code)
    );

    // Next values of control state
    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !advance);
        pos_next       = pos_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            if (last_reg)
            begin
                pos_next       = '0;
                flags_next     = ALL_FLAGS;
                out_valid_next = 1'b1;
            end
            else
            begin
                flags_next = flags_upd;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            flags_reg     <= ALL_FLAGS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (advance && last_reg)
        begin
            container_reg <= code;
        end
    end

    assign out_valid = out_valid_reg;
    assign container = container_reg;

    // A result code never exceeds the last defined container
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (container_reg <= CODE_MTS))
        else $error("container code out of range");

    // Finishing a buffer returns position and flags to their start values
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (pos_reg == '0) && (flags_reg == ALL_FLAGS))
        else $error("state not restarted after last byte");

    // Position saturates instead of wrapping
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last_reg && (pos_reg == POS_MAX)) |=> (pos_reg == POS_MAX))
        else $error("byte position wrapped");

    // A stalled result is never overwritten by a new buffer's result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(advance && last_reg))
        else $error("held result overwritten");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the video container sniffer: byte stream driver, result monitor, signature predictor.
`timescale 1ns / 100ps

module tb_top;
    import vcs_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       eob;
        bit         hold_for_idle;
    } stim_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] container;

    stim_word_t stim_q [$];
    container_t expected_codes [$];

    // Predictor state: offset of the next byte and the signatures still possible
    logic [POS_W-1:0]    scan_pos;
    logic [NUM_SIGS-1:0] sig_alive;

    int mismatch_cnt = 0;
    int results_seen = 0;

    video_container_sniffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .container (container)
    );

    always #5 clk = ~clk;

    // Advance the sniffer state by one byte; returns 1 when a buffer closes
    function automatic bit sniff_step(input logic [7:0] b, input logic eob,
                                      output container_t code);
        logic [NUM_SIGS-1:0] alive;
        logic [LEN_W-1:0]    len;
        int                  i;
        alive = sig_alive;
        code = CODE_UNKNOWN;
        if (scan_pos < HEAD_LEN) begin
            for (i = 0; i < NUM_HEAD_SIGS; i++)
                if (SIG_CARE[i][scan_pos[3:0]] && SIG_BYTES[i][scan_pos[3:0]] != b)
                    alive[i] = 1'b0;
        end
        if ((scan_pos == 0 || scan_pos == TS_POS_A || scan_pos == TS_POS_B) && b != TS_SYNC)
            alive[TS_FLAG_BIT] = 1'b0;
        if (!eob) begin
            sig_alive = alive;
            if (scan_pos != POS_MAX)
                scan_pos = scan_pos + 1'b1;
            return 1'b0;
        end
        // final byte: drop signatures whose minimum length was not reached
        len = {1'b0, scan_pos} + 1'b1;
        for (i = 0; i < NUM_HEAD_SIGS; i++)
            if (len < SIG_MIN_LEN[i])
                alive[i] = 1'b0;
        if (len < TS_MIN_LEN)
            alive[TS_FLAG_BIT] = 1'b0;
        // lowest index wins
        for (i = NUM_SIGS - 1; i >= 0; i--)
            if (alive[i])
                code = container_t'(i + 1);
        scan_pos = '0;
        sig_alive = ALL_FLAGS;
        return 1'b1;
    endfunction

    // Queue one buffer: random or constant fill, overlay signature first, then the main one
    task automatic add_buffer(input container_t kind, input container_t overlay, input int len,
                              input int fill, input bit corrupt, input bit drain);
        logic [7:0] octets [];
        int         hits [$];
        int         ts_at [3];
        container_t k;
        stim_word_t w;
        int         sig;
        int         n;
        int         p;
        octets = new[len];
        ts_at = '{0, int'(TS_POS_A), int'(TS_POS_B)};
        foreach (octets[j])
            octets[j] = (fill < 0) ? 8'($urandom) : 8'(fill);
        for (n = 0; n < 2; n++) begin
            k = (n == 0) ? overlay : kind;
            if (k == CODE_MTS) begin
                foreach (ts_at[j])
                    if (ts_at[j] < len) begin
                        octets[ts_at[j]] = TS_SYNC;
                        if (n == 1)
                            hits.push_back(ts_at[j]);
                    end
            end else if (k != CODE_UNKNOWN) begin
                sig = int'(k) - 1;
                for (p = 0; p < HEAD_LEN && p < len; p++)
                    if (SIG_CARE[sig][p]) begin
                        octets[p] = SIG_BYTES[sig][p];
                        if (n == 1)
                            hits.push_back(p);
                    end
            end
        end
        // break one signature byte
        if (corrupt && hits.size() != 0) begin
            p = hits[$urandom_range(0, hits.size() - 1)];
            octets[p] = octets[p] ^ 8'($urandom_range(1, 255));
        end
        for (p = 0; p < len; p++) begin
            w.value = octets[p];
            w.eob = (p == len - 1);
            w.hold_for_idle = drain && (p == 0);
            stim_q.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_cnt < 10)
            $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $realtime);
        mismatch_cnt++;
    endtask

    // Driver: bursts of words with random gaps, predicts on every accepted word
    always @(posedge clk) begin : drive_words
        container_t code;
        stim_word_t nxt;
        int         burst_left;
        int         gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            scan_pos = '0;
            sig_alive = ALL_FLAGS;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                if (sniff_step(data_byte, last_byte, code))
                    expected_codes.push_back(code);
            end
            // a stalled word stays put
            if (!(in_valid && in_stall)) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (stim_q.size() != 0 &&
                             !(stim_q[0].hold_for_idle && expected_codes.size() != 0)) begin
                    nxt = stim_q.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.value;
                    last_byte <= nxt.eob;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with two long hold-offs to back up the input
    always @(posedge clk) begin : stall_pattern
        int stall_mode;
        int mode_left;
        int hold_left;
        int hold_stage;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_mode = 0;
            mode_left = 50;
            hold_left = 0;
            hold_stage = 0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if ((hold_stage == 0 && results_seen >= 8) ||
                     (hold_stage == 1 && results_seen >= 20)) begin
            out_stall <= 1'b1;
            hold_left = 300;
            hold_stage++;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Monitor: every accepted result against the oldest expectation
    always @(posedge clk) begin : check_results
        container_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_codes.size() == 0) begin
                report_mismatch("unexpected container", -1, int'(container));
            end else begin
                want = expected_codes.pop_front();
                if (container !== want)
                    report_mismatch("container", int'(want), int'(container));
            end
        end
    end

    // Stimulus and end of run
    initial begin
        container_t kind;
        container_t overlay;
        int         directed_words;
        int         n_bufs;
        int         pick;
        int         min_len;
        int         len;
        bit         drain;

        // directed: field extremes, each signature at its minimum length, most also just below it
        add_buffer(CODE_UNKNOWN, CODE_UNKNOWN, 1, 8'h00, 0, 0);
        add_buffer(CODE_UNKNOWN, CODE_UNKNOWN, 1, 8'hFF, 0, 0);
        add_buffer(CODE_MTS, CODE_UNKNOWN, 1, -1, 0, 0);
        add_buffer(CODE_MKV, CODE_UNKNOWN, 4, -1, 0, 0);
        add_buffer(CODE_MKV, CODE_UNKNOWN, 3, -1, 0, 0);
        add_buffer(CODE_MP4, CODE_UNKNOWN, 8, 8'h00, 0, 0);
        add_buffer(CODE_MP4, CODE_UNKNOWN, 7, -1, 0, 0);
        add_buffer(CODE_AVI, CODE_UNKNOWN, 12, -1, 0, 0);
        add_buffer(CODE_AVI, CODE_UNKNOWN, 11, -1, 0, 0);
        add_buffer(CODE_AVI, CODE_UNKNOWN, 20, -1, 1, 0);
        add_buffer(CODE_MPS, CODE_UNKNOWN, 4, 8'hFF, 0, 0);
        add_buffer(CODE_ASF, CODE_UNKNOWN, 16, -1, 0, 0);
        add_buffer(CODE_ASF, CODE_UNKNOWN, 15, -1, 0, 0);
        add_buffer(CODE_FLV, CODE_UNKNOWN, 3, -1, 0, 0);
        add_buffer(CODE_FLV, CODE_UNKNOWN, 2, -1, 0, 0);
        add_buffer(CODE_OGG, CODE_UNKNOWN, 4, -1, 0, 0);
        add_buffer(CODE_RM, CODE_UNKNOWN, 4, -1, 0, 0);
        add_buffer(CODE_RM, CODE_UNKNOWN, 9, -1, 1, 0);
        // priority between signatures that can both hold
        add_buffer(CODE_MP4, CODE_MKV, 8, -1, 0, 0);
        add_buffer(CODE_MPS, CODE_MP4, 10, -1, 0, 1);
        // mp4 over transport stream, long enough to saturate the position
        add_buffer(CODE_MP4, CODE_MTS, 515, -1, 0, 0);
        // transport stream at and below the minimum
        add_buffer(CODE_MTS, CODE_UNKNOWN, 377, -1, 0, 0);
        add_buffer(CODE_MTS, CODE_UNKNOWN, 376, -1, 0, 0);
        directed_words = stim_q.size();

        // random: mostly well-formed headers with random content, some broken or short
        n_bufs = 0;
        while (stim_q.size() < directed_words + 140) begin
            pick = $urandom_range(0, 99);
            drain = (n_bufs % 5 == 4);
            if (pick < 8) begin
                add_buffer(CODE_UNKNOWN, CODE_UNKNOWN, $urandom_range(1, 24), -1, 0, drain);
            end else if (pick < 96) begin
                kind = container_t'($urandom_range(1, 8));
                min_len = int'(SIG_MIN_LEN[int'(kind) - 1]);
                len = $urandom_range(0, 99);
                if (len < 15)
                    len = min_len - 1;
                else if (len < 85)
                    len = min_len + $urandom_range(0, 6);
                else
                    len = min_len + $urandom_range(7, 40);
                overlay = (kind != CODE_ASF && kind != CODE_MP4 && $urandom_range(0, 9) == 0)
                          ? CODE_MP4 : CODE_UNKNOWN;
                add_buffer(kind, overlay, len, -1, $urandom_range(0, 4) == 0, drain);
            end else if (pick < 99) begin
                add_buffer(CODE_MTS, CODE_UNKNOWN, 376 + $urandom_range(0, 24), -1,
                           $urandom_range(0, 3) == 0, drain);
            end else begin
                add_buffer($urandom_range(0, 1) ? CODE_MTS : CODE_UNKNOWN, CODE_UNKNOWN,
                           $urandom_range(512, 560), -1, 0, drain);
            end
            n_bufs++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all words taken, all results back, then a few idle cycles
        while (stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_cnt == 0 && expected_codes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/vcs_pkg.sv
src/vcs_match.sv
src/video_container_sniffer.sv
sim/tb_top.sv
